// ===== rtl/trle_pkg.sv =====
// ----------------------------------------------------------------------------
// trle_pkg
// Types and constants shared by the tile run-length decoder modules.
// ----------------------------------------------------------------------------
package trle_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 7;
  localparam int unsigned CountW = 2;

  localparam logic [ByteW-1:0] LenMask = 8'h7F;
  localparam logic [ByteW-1:0] LitFlag = 8'h80;

  localparam logic [CountW-1:0] CountNone = 2'd0;
  localparam logic [CountW-1:0] CountOne  = 2'd1;
  localparam logic [CountW-1:0] CountTwo  = 2'd2;

  typedef enum logic [2:0] {
    PhCtrl = 3'b001,
    PhLit  = 3'b010,
    PhRep  = 3'b100
  } phase_e;

  // One queued request: emit 'count' copies of 'data', packed two per result.
  // A zero count is queued only for a final byte and yields one empty result.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [LenW-1:0]  count;
    logic             fin;
    logic             trunc;
  } cmd_t;

endpackage

// ===== rtl/trle_stream_if.sv =====
// ----------------------------------------------------------------------------
// trle_stream_if
// Valid/ready channels for compressed input bytes and decoded results.
// ----------------------------------------------------------------------------
interface trle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

interface trle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_a;
  logic [7:0] byte_b;
  logic [1:0] byte_count;
  logic       run_done;
  logic       stream_end;
  logic       truncated;

  modport source (
    output valid, output byte_a, output byte_b, output byte_count,
    output run_done, output stream_end, output truncated, input ready
  );
  modport sink (
    input valid, input byte_a, input byte_b, input byte_count,
    input run_done, input stream_end, input truncated, output ready
  );
endinterface

// ===== rtl/trle_front.sv =====
// ----------------------------------------------------------------------------
// trle_front
// Parses the compressed byte stream and turns each byte into an expansion
// request for the back end.
// ----------------------------------------------------------------------------
module trle_front import trle_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             is_final_i,
  input  logic             full_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] run_left_q, run_left_d;
  logic [LenW-1:0] len;
  logic            accept;

  assign in_ready_o = ~full_i;
  assign accept     = in_valid_i & ~full_i;
  assign len        = LenW'(in_byte_i & LenMask);

  always_comb begin
    cmd_o.data  = in_byte_i;
    cmd_o.count = '0;
    cmd_o.fin   = is_final_i;
    phase_d     = phase_q;
    run_left_d  = run_left_q;
    case (phase_q)
      PhLit: begin
        cmd_o.count = LenW'(1);
        run_left_d  = run_left_q - LenW'(1);
        phase_d     = (run_left_d == '0) ? PhCtrl : PhLit;
      end
      PhRep: begin
        cmd_o.count = run_left_q;
        run_left_d  = '0;
        phase_d     = PhCtrl;
      end
      default: begin
        run_left_d = len;
        if ((in_byte_i & LitFlag) != '0) begin
          phase_d = (len != '0) ? PhLit : PhCtrl;
        end else begin
          phase_d = PhRep;
        end
      end
    endcase
    cmd_o.trunc = is_final_i & (phase_d != PhCtrl);
    if (is_final_i) begin
      phase_d    = PhCtrl;
      run_left_d = '0;
    end
  end

  assign push_o = accept & ((cmd_o.count != '0) | is_final_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhCtrl;
      run_left_q <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      run_left_q <= run_left_d;
    end
  end

endmodule

// ===== rtl/trle_fifo.sv =====
// ----------------------------------------------------------------------------
// trle_fifo
// Short request queue between the stream parser and the run expander.
// ----------------------------------------------------------------------------
module trle_fifo import trle_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] fill_q;

  assign full_o  = (fill_q == CntW'(Depth));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/trle_back.sv =====
// ----------------------------------------------------------------------------
// trle_back
// Expands queued requests into packed results, two bytes per result, and
// holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module trle_back import trle_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  cmd_t              head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ByteW-1:0]  byte_a_o,
  output logic [ByteW-1:0]  byte_b_o,
  output logic [CountW-1:0] byte_count_o,
  output logic              run_done_o,
  output logic              stream_end_o,
  output logic              truncated_o
);

  logic              active_q;
  logic [LenW-1:0]   left_q;
  logic [ByteW-1:0]  data_q;
  logic              fin_q, trunc_q;
  logic              valid_q;

  logic [LenW-1:0]   src_left;
  logic [ByteW-1:0]  src_data;
  logic              src_fin, src_trunc;
  logic [CountW-1:0] cnt;
  logic              last, slot_free, emit;

  assign src_left  = active_q ? left_q  : head_i.count;
  assign src_data  = active_q ? data_q  : head_i.data;
  assign src_fin   = active_q ? fin_q   : head_i.fin;
  assign src_trunc = active_q ? trunc_q : head_i.trunc;

  assign cnt       = (src_left >= LenW'(2)) ? CountTwo : src_left[CountW-1:0];
  assign last      = (src_left <= LenW'(2));
  assign slot_free = ~valid_q | out_ready_i;
  assign emit      = slot_free & (active_q | ~empty_i);
  assign pop_o     = emit & ~active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      if (emit) begin
        active_q <= ~last;
        valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      left_q       <= src_left - LenW'(cnt);
      data_q       <= src_data;
      fin_q        <= src_fin;
      trunc_q      <= src_trunc;
      byte_a_o     <= (cnt != CountNone) ? src_data : '0;
      byte_b_o     <= (cnt == CountTwo) ? src_data : '0;
      byte_count_o <= cnt;
      run_done_o   <= last;
      stream_end_o <= last & src_fin;
      truncated_o  <= last & src_fin & src_trunc;
    end
  end

  assign out_valid_o = valid_q;

endmodule

// ===== rtl/tile_rle_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tile_rle_decoder_top
// Run-length decoder for a compressed tile stream, one byte per request in,
// up to two decoded bytes per request out.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in_i     in   in_byte[7:0], is_final
// out_o    out  byte_a[7:0], byte_b[7:0], byte_count[1:0], run_done,
//               stream_end, truncated
//
// The parser takes one input byte per cycle while the request queue has room.
// The expander emits one result per cycle while the receiver takes them, so a
// repeat run of n bytes takes ceil(n/2) results and backs the queue up behind it.
// Reset clears the parser state, the queue and the output register.
// Either side may stall; the queue and output register decouple them.
// ----------------------------------------------------------------------------
module tile_rle_decoder_top import trle_pkg::*; #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  trle_in_if.sink    in_i,
  trle_out_if.source out_o
);

  cmd_t push_cmd, head_cmd;
  logic push, full, pop, empty;

  trle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_byte_i  (in_i.in_byte),
    .is_final_i (in_i.is_final),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  trle_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_cmd)
  );

  trle_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .byte_a_o     (out_o.byte_a),
    .byte_b_o     (out_o.byte_b),
    .byte_count_o (out_o.byte_count),
    .run_done_o   (out_o.run_done),
    .stream_end_o (out_o.stream_end),
    .truncated_o  (out_o.truncated)
  );

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for tile_rle_decoder_top. Compressed streams of
// literal and repeat runs are sent one byte per request while both channels
// stall at random. A model of the decoder predicts the packed results, and
// every result that leaves the block is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import trle_pkg::*;

  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic [ByteW-1:0]  byte_a;
    logic [ByteW-1:0]  byte_b;
    logic [CountW-1:0] count;
    logic              run_done;
    logic              stream_end;
    logic              truncated;
  } decoded_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  trle_in_if  in_if ();
  trle_out_if out_if ();

  tile_rle_decoder_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #2 clk_i = ~clk_i;

  phase_e         rle_phase = PhCtrl;
  logic [LenW-1:0] rle_left = '0;
  decoded_t       decoded_q[$];

  bit          no_idle     = 1'b0;
  int unsigned rx_hold_len = 0;
  int unsigned n_sent      = 0;
  int unsigned n_checked   = 0;
  int unsigned n_errors    = 0;
  int unsigned n_streams   = 0;
  int unsigned n_cut       = 0;
  int unsigned idle_cycles = 0;

  function automatic string fmt_decoded(input decoded_t d);
    return $sformatf("a=%02h b=%02h cnt=%0d done=%0b end=%0b trunc=%0b",
                     d.byte_a, d.byte_b, d.count, d.run_done, d.stream_end,
                     d.truncated);
  endfunction

  function automatic void flag_error(input string msg);
    n_errors++;
    if (n_errors <= MaxReports) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endfunction

  // Works out the results that one compressed byte causes and queues them.
  function automatic void decode_byte(input logic [ByteW-1:0] b, input logic fin);
    decoded_t        outs[$];
    int unsigned     left;
    logic [ByteW-1:0] len;
    case (rle_phase)
      PhLit: begin
        outs.push_back('{b, 8'h00, CountOne, 1'b0, 1'b0, 1'b0});
        rle_left = rle_left - LenW'(1);
        if (rle_left == '0) rle_phase = PhCtrl;
      end
      PhRep: begin
        left = rle_left;
        while (left >= 2) begin
          outs.push_back('{b, b, CountTwo, 1'b0, 1'b0, 1'b0});
          left -= 2;
        end
        if (left == 1) outs.push_back('{b, 8'h00, CountOne, 1'b0, 1'b0, 1'b0});
        rle_phase = PhCtrl;
        rle_left  = '0;
      end
      default: begin
        len      = b & LenMask;
        rle_left = len[LenW-1:0];
        if ((b & LitFlag) != '0) begin
          rle_phase = (len != '0) ? PhLit : PhCtrl;
        end else begin
          rle_phase = PhRep;
        end
      end
    endcase
    if (fin && outs.size() == 0) outs.push_back('{8'h00, 8'h00, CountNone, 1'b0, 1'b0, 1'b0});
    if (outs.size() > 0) outs[outs.size()-1].run_done = 1'b1;
    if (fin) begin
      outs[outs.size()-1].stream_end = 1'b1;
      outs[outs.size()-1].truncated  = (rle_phase == PhLit || rle_phase == PhRep);
      n_streams++;
      if (outs[outs.size()-1].truncated) n_cut++;
      rle_phase = PhCtrl;
      rle_left  = '0;
    end
    foreach (outs[i]) decoded_q.push_back(outs[i]);
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input logic fin);
    while (!no_idle && $urandom_range(99) < 8) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.in_byte  <= b;
    in_if.is_final <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    n_sent++;
    decode_byte(b, fin);
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 75) return $urandom_range(8, 1);
    if (r < 95) return $urandom_range(40, 9);
    if (r < 98) return $urandom_range(126, 41);
    return 127;
  endfunction

  // Builds a well-formed stream of runs; a broken one is cut at a random byte.
  task automatic send_stream(input int unsigned n_runs, input bit broken);
    logic [ByteW-1:0] bytes[$];
    int unsigned      len;
    int unsigned      cut;
    repeat (n_runs) begin
      len = pick_len();
      if ($urandom_range(1)) begin
        bytes.push_back(LitFlag | len[ByteW-1:0]);
        repeat (len) bytes.push_back(ByteW'($urandom_range(255)));
      end else begin
        bytes.push_back(len[ByteW-1:0]);
        bytes.push_back(ByteW'($urandom_range(255)));
      end
    end
    cut = broken ? $urandom_range(bytes.size(), 1) : bytes.size();
    for (int unsigned i = 0; i < cut; i++) begin
      send_byte(bytes[i], i == cut - 1);
    end
  endtask

  task automatic test_directed();
    send_byte(8'h83, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7E, 1'b1);
    send_byte(8'h05, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h82, 1'b0);
    send_byte(8'h11, 1'b1);
    send_byte(8'h03, 1'b0);
    send_byte(8'h33, 1'b1);
  endtask

  // The receiver holds off while long repeat runs keep arriving, so the
  // request queue fills and the input channel has to stall.
  task automatic test_backpressure();
    rx_hold_len = 300;
    no_idle     = 1'b1;
    repeat (6) begin
      send_byte(8'h7F, 1'b0);
      send_byte(ByteW'($urandom_range(255)), 1'b0);
    end
    send_byte(8'h84, 1'b0);
    repeat (4) send_byte(ByteW'($urandom_range(255)), 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(ByteW'($urandom_range(255)), 1'b1);
    no_idle = 1'b0;
  endtask

  task automatic test_random_streams(input int unsigned n_items);
    int unsigned start;
    int unsigned done;
    start = n_sent;
    done  = 0;
    while (done < n_items) begin
      no_idle = (done >= n_items / 3) && (done < n_items / 3 + 80);
      if ($urandom_range(9) == 0) begin
        send_byte(ByteW'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        send_stream($urandom_range(6, 1), $urandom_range(4) == 0);
      end
      done = n_sent - start;
    end
    no_idle = 1'b0;
  endtask

  initial begin : rx_side
    int unsigned hold_cnt;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_len != 0) begin
        hold_cnt    = rx_hold_len;
        rx_hold_len = 0;
        out_if.ready <= 1'b0;
        repeat (hold_cnt - 1) @(posedge clk_i);
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk_i) begin : check_decoded
    decoded_t got;
    decoded_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.byte_a, out_if.byte_b, out_if.byte_count, out_if.run_done,
              out_if.stream_end, out_if.truncated};
      if (decoded_q.size() == 0) begin
        flag_error($sformatf("unexpected result: %s", fmt_decoded(got)));
      end else begin
        want = decoded_q.pop_front();
        n_checked++;
        if (got !== want) begin
          flag_error($sformatf("result %0d mismatch: expected %s, got %s",
                               n_checked, fmt_decoded(want), fmt_decoded(got)));
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("[%0t] ERROR: no request moved for %0d cycles, %0d results pending",
                 $realtime, StallLimit, decoded_q.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.in_byte  = '0;
    in_if.is_final = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_backpressure();
    test_random_streams(380);

    in_if.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (decoded_q.size() != 0) begin
      flag_error($sformatf("%0d expected results never arrived", decoded_q.size()));
    end

    $display("Sent %0d compressed bytes in %0d streams (%0d cut off), checked %0d results.",
             n_sent, n_streams, n_cut, n_checked);
    $display("Runs of length 0 to 127 were decoded under random stalls and a long hold-off.");
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors in total.", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/trle_pkg.sv
rtl/trle_stream_if.sv
rtl/trle_front.sv
rtl/trle_fifo.sv
rtl/trle_back.sv
rtl/tile_rle_decoder_top.sv
dv/tb.sv
